// File: design/hist2d_pkg.sv
// Shared definitions for the two-dimensional histogram binner.
// Field widths, operation codes, register indexes and reset values.
// No dependencies.
package hist2d_pkg;

	// Default grid size, one side of the square histogram.
	localparam int RESOLUTION_DEF = 256;

	// Field widths.
	localparam int FUNC_W     = 2;
	localparam int SAMPLE_W   = 16;
	localparam int SCALE_W    = 24;
	localparam int FRAC_W     = 16;
	localparam int RDCOORD_W  = 8;
	localparam int COUNT_W    = 32;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 24;
	localparam int PROD_W     = SAMPLE_W + SCALE_W;

	// Stream payload widths.
	localparam int S_DATA_W = 2 * SAMPLE_W + 2 * RDCOORD_W;
	localparam int M_DATA_W = 2 * COUNT_W;

	typedef logic [FUNC_W-1:0]    func_t;
	typedef logic [CFG_IDX_W-1:0] reg_idx_t;

	// Operation codes carried in the input tuser.
	localparam func_t FUNC_CLEAR = 2'd0;
	localparam func_t FUNC_ACCUM = 2'd1;
	localparam func_t FUNC_READ  = 2'd2;

	// Configuration register indexes.
	localparam reg_idx_t REG_U_OFFSET = 2'd0;
	localparam reg_idx_t REG_V_OFFSET = 2'd1;
	localparam reg_idx_t REG_U_SCALE  = 2'd2;
	localparam reg_idx_t REG_V_SCALE  = 2'd3;

	// Reset values of the scale registers: 1.0 in Q8.16.
	localparam logic [SCALE_W-1:0] SCALE_ONE = 24'h01_0000;

	localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

endpackage

// File: design/two_d_histogram_binner.sv
// Top level of the two-dimensional histogram binner.
// Depends on hist2d_pkg and hist2d_ram (the bin store).
//
// The block works on one beat at a time. An accumulate or read beat goes through five
// steps before the next beat is accepted: the offset samples are registered at
// acceptance, then the scale multiply, the clip that forms the bin address, the bin
// store read and the write-back, which loads the result register and waits while
// that register is full and not taken. A clear beat sweeps the bin store one entry per
// cycle; its result leaves at the end of the sweep. After reset the same sweep runs,
// with no result, before the first beat is taken. A finished result waits in the
// output register while the next beat is already accepted and worked on.
// Configuration writes are always taken and should be made while idle.
module two_d_histogram_binner
	import hist2d_pkg::*;
#(
	parameter int RESOLUTION = RESOLUTION_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_tvalid,
	output logic                  s_tready,
	// u_sample[15:0], v_sample[31:16], read_u[39:32], read_v[47:40]
	input  logic [S_DATA_W-1:0]   s_tdata,
	// func[1:0]
	input  logic [FUNC_W-1:0]     s_tuser,
	output logic                  m_tvalid,
	input  logic                  m_tready,
	// bin_count[31:0], peak_count[63:32]
	output logic [M_DATA_W-1:0]   m_tdata,
	// saturated[0]
	output logic                  m_tuser,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	localparam int CW    = $clog2(RESOLUTION);
	localparam int DEPTH = RESOLUTION * RESOLUTION;
	localparam int AW    = $clog2(DEPTH);
	localparam int IW    = SCALE_W;

	localparam logic [CW-1:0] COORD_LAST = CW'(RESOLUTION - 1);
	localparam logic [IW-1:0] COORD_LIM  = IW'(RESOLUTION - 1);
	localparam logic [AW-1:0] ROW_SIZE   = AW'(RESOLUTION);
	localparam logic [AW-1:0] ADDR_LAST  = AW'(DEPTH - 1);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MUL,
		ST_ADDR,
		ST_READ,
		ST_WB,
		ST_CLR
	} state_t;

	// Configuration registers.
	logic [SAMPLE_W-1:0] u_offset_q;
	logic [SAMPLE_W-1:0] v_offset_q;
	logic [SCALE_W-1:0]  u_scale_q;
	logic [SCALE_W-1:0]  v_scale_q;

	// Control state.
	state_t              state_q;
	logic [AW-1:0]       clr_cnt_q;
	logic                clr_emit_q;
	logic [COUNT_W-1:0]  peak_q;
	logic                out_valid_q;
	logic [COUNT_W-1:0]  out_bin_q;
	logic [COUNT_W-1:0]  out_peak_q;
	logic                out_sat_q;

	// Item payload registers.
	func_t               func_q;
	logic                u_pos_q;
	logic                v_pos_q;
	logic [SAMPLE_W-1:0] u_mag_q;
	logic [SAMPLE_W-1:0] v_mag_q;
	logic [RDCOORD_W-1:0] rd_u_q;
	logic [RDCOORD_W-1:0] rd_v_q;
	logic [PROD_W-1:0]   u_prod_q;
	logic [PROD_W-1:0]   v_prod_q;
	logic [AW-1:0]       addr_q;
	logic                hit_q;

	// Datapath signals.
	logic                s_fire;
	logic                out_free;
	logic                out_load;
	logic [SAMPLE_W:0]   u_diff;
	logic [SAMPLE_W:0]   v_diff;
	logic [IW-1:0]       u_int;
	logic [IW-1:0]       v_int;
	logic [CW-1:0]       u_coord;
	logic [CW-1:0]       v_coord;
	logic [CW-1:0]       u_sel;
	logic [CW-1:0]       v_sel;
	logic                rd_in_grid;
	logic [COUNT_W-1:0]  ram_rdata;
	logic [COUNT_W-1:0]  bumped;
	logic [COUNT_W-1:0]  wb_count;
	logic [COUNT_W-1:0]  wb_peak;
	logic                ram_we;
	logic [AW-1:0]       ram_waddr;
	logic [COUNT_W-1:0]  ram_wdata;
	logic                ram_re;

	assign s_tready  = (state_q == ST_IDLE);
	assign s_fire    = s_tvalid && s_tready;
	assign out_free  = !out_valid_q || m_tready;
	assign cfg_ready = 1'b1;

	// A new result enters the output register at this edge.
	assign out_load = out_free && ((state_q == ST_WB)
		|| ((state_q == ST_CLR) && (clr_cnt_q == ADDR_LAST) && clr_emit_q));

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {out_peak_q, out_bin_q};
	assign m_tuser  = out_sat_q;

	// Configuration register writes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			u_offset_q <= '0;
			v_offset_q <= '0;
			u_scale_q  <= SCALE_ONE;
			v_scale_q  <= SCALE_ONE;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_U_OFFSET: u_offset_q <= cfg_data[SAMPLE_W-1:0];
				REG_V_OFFSET: v_offset_q <= cfg_data[SAMPLE_W-1:0];
				REG_U_SCALE:  u_scale_q  <= cfg_data[SCALE_W-1:0];
				REG_V_SCALE:  v_scale_q  <= cfg_data[SCALE_W-1:0];
				default: ;
			endcase
		end
	end

	// Offset subtraction at acceptance; the difference is exact in 17 bits.
	assign u_diff = {s_tdata[SAMPLE_W-1], s_tdata[SAMPLE_W-1:0]}
		- {u_offset_q[SAMPLE_W-1], u_offset_q};
	assign v_diff = {s_tdata[2*SAMPLE_W-1], s_tdata[2*SAMPLE_W-1:SAMPLE_W]}
		- {v_offset_q[SAMPLE_W-1], v_offset_q};

	// Integer part of the scaled value, clipped to the grid; zero or negative gives 0.
	assign u_int = u_prod_q[PROD_W-1:FRAC_W];
	assign v_int = v_prod_q[PROD_W-1:FRAC_W];

	always_comb begin
		if (!u_pos_q) begin
			u_coord = '0;
		end else if (u_int > COORD_LIM) begin
			u_coord = COORD_LAST;
		end else begin
			u_coord = u_int[CW-1:0];
		end
		if (!v_pos_q) begin
			v_coord = '0;
		end else if (v_int > COORD_LIM) begin
			v_coord = COORD_LAST;
		end else begin
			v_coord = v_int[CW-1:0];
		end
	end

	// Bin coordinates: computed ones for an accumulate, given ones for a read.
	assign rd_in_grid = (32'(rd_u_q) < 32'(RESOLUTION)) && (32'(rd_v_q) < 32'(RESOLUTION));
	assign u_sel = (func_q == FUNC_ACCUM) ? u_coord : CW'(rd_u_q);
	assign v_sel = (func_q == FUNC_ACCUM) ? v_coord : CW'(rd_v_q);

	// Item payload pipeline: capture, multiply, address.
	always_ff @(posedge clk) begin
		if (s_fire) begin
			func_q  <= s_tuser;
			u_pos_q <= !u_diff[SAMPLE_W] && (u_diff != '0);
			v_pos_q <= !v_diff[SAMPLE_W] && (v_diff != '0);
			u_mag_q <= u_diff[SAMPLE_W-1:0];
			v_mag_q <= v_diff[SAMPLE_W-1:0];
			rd_u_q  <= s_tdata[2*SAMPLE_W+RDCOORD_W-1:2*SAMPLE_W];
			rd_v_q  <= s_tdata[S_DATA_W-1:2*SAMPLE_W+RDCOORD_W];
		end
		if (state_q == ST_MUL) begin
			u_prod_q <= PROD_W'(u_mag_q) * PROD_W'(u_scale_q);
			v_prod_q <= PROD_W'(v_mag_q) * PROD_W'(v_scale_q);
		end
		if (state_q == ST_ADDR) begin
			addr_q <= AW'(u_sel) * ROW_SIZE + AW'(v_sel);
			hit_q  <= (func_q == FUNC_ACCUM) || ((func_q == FUNC_READ) && rd_in_grid);
		end
	end

	// Write-back values: saturating increment and the running peak.
	assign bumped  = (ram_rdata == COUNT_MAX) ? ram_rdata : ram_rdata + COUNT_W'(1);
	always_comb begin
		wb_peak = peak_q;
		if (func_q == FUNC_ACCUM) begin
			wb_count = bumped;
			if (bumped > peak_q) begin
				wb_peak = bumped;
			end
		end else if (hit_q) begin
			wb_count = ram_rdata;
		end else begin
			wb_count = '0;
		end
	end

	// Bin store access: sweep writes zeros, accumulate write-back stores the new count.
	assign ram_we    = (state_q == ST_CLR)
		|| ((state_q == ST_WB) && out_free && (func_q == FUNC_ACCUM));
	assign ram_waddr = (state_q == ST_CLR) ? clr_cnt_q : addr_q;
	assign ram_wdata = (state_q == ST_CLR) ? '0 : bumped;
	assign ram_re    = (state_q == ST_READ);

	hist2d_ram #(
		.WIDTH (COUNT_W),
		.DEPTH (DEPTH)
	) u_bin_store (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (addr_q),
		.rdata (ram_rdata)
	);

	// Sequencer, peak register and result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLR;
			clr_cnt_q   <= '0;
			clr_emit_q  <= 1'b0;
			peak_q      <= '0;
			out_valid_q <= 1'b0;
			out_bin_q   <= '0;
			out_peak_q  <= '0;
			out_sat_q   <= 1'b0;
		end else begin
			// The result register empties once taken unless a new result loads it.
			if (out_valid_q && m_tready && !out_load) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (s_fire) begin
						if (s_tuser == FUNC_CLEAR) begin
							state_q    <= ST_CLR;
							clr_cnt_q  <= '0;
							clr_emit_q <= 1'b1;
							peak_q     <= '0;
						end else begin
							state_q <= ST_MUL;
						end
					end
				end
				ST_MUL: begin
					state_q <= ST_ADDR;
				end
				ST_ADDR: begin
					state_q <= ST_READ;
				end
				ST_READ: begin
					state_q <= ST_WB;
				end
				ST_WB: begin
					if (out_free) begin
						peak_q      <= wb_peak;
						out_valid_q <= 1'b1;
						out_bin_q   <= wb_count;
						out_peak_q  <= wb_peak;
						out_sat_q   <= (wb_count == COUNT_MAX);
						state_q     <= ST_IDLE;
					end
				end
				ST_CLR: begin
					// The last entry is rewritten while the clear result waits.
					if (clr_cnt_q != ADDR_LAST) begin
						clr_cnt_q <= clr_cnt_q + AW'(1);
					end else if (!clr_emit_q) begin
						state_q <= ST_IDLE;
					end else if (out_free) begin
						out_valid_q <= 1'b1;
						out_bin_q   <= '0;
						out_peak_q  <= '0;
						out_sat_q   <= 1'b0;
						state_q     <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// The saturation flag always matches the reported count.
	a_sat_flag: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tuser == (m_tdata[COUNT_W-1:0] == COUNT_MAX)))
		else $error("saturated flag disagrees with bin count");

	// No bin can exceed the running peak.
	a_peak_bound: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tdata[COUNT_W-1:0] <= m_tdata[M_DATA_W-1:COUNT_W]))
		else $error("bin count above peak count");

	// A clear beat starts a sweep from the first entry with the peak zeroed.
	a_clear_start: assert property (@(posedge clk) disable iff (!arst_n)
		(s_fire && (s_tuser == FUNC_CLEAR))
		|=> ((state_q == ST_CLR) && (clr_cnt_q == '0) && (peak_q == '0)))
		else $error("clear beat did not start a sweep");

	// The store is written only by the sweep or by an accumulate write-back.
	a_store_write: assert property (@(posedge clk) disable iff (!arst_n)
		ram_we |-> ((state_q == ST_CLR) || ((state_q == ST_WB) && (func_q == FUNC_ACCUM))))
		else $error("unexpected bin store write");

endmodule

// File: design/hist2d_ram.sv
// Generic simple dual-port RAM with one write port and one registered read port.
// Read data appears in the cycle after the read enable and holds until the next read.
// No dependencies.
module hist2d_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// Registered read port.
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule
